// File: rtl/core/msq_pkg.sv
// Package with the shared constants, types and codes of the message queue.
package msq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_ENQ   = 2'd0;
  localparam logic [1:0] CMD_DEQ   = 2'd1;
  localparam logic [1:0] CMD_PEEK  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] MODE_FIFO = 2'd0;
  localparam logic [1:0] MODE_LIFO = 2'd1;
  localparam logic [1:0] MODE_PRIO = 2'd2;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_CAP  = 3'd4;

  typedef struct packed {
    logic [31:0]        payload;
    logic [15:0]        length;
    logic signed [15:0] prio;
    logic [31:0]        seq_num;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT
  } state_t;

endpackage

// File: rtl/core/msq_if.sv
// Valid/ready channel interfaces for commands and results.
interface msq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [31:0]        payload;
  logic [15:0]        msg_length;
  logic signed [15:0] msg_priority;
  modport source (output valid, cmd, payload, msg_length, msg_priority, input ready);
  modport sink   (input valid, cmd, payload, msg_length, msg_priority, output ready);
endinterface

interface msq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [31:0]        out_payload;
  logic [15:0]        out_length;
  logic signed [15:0] out_priority;
  logic [31:0]        out_sequence;
  logic [6:0]         occupancy;
  modport source (output valid, status, out_payload, out_length, out_priority,
                  out_sequence, occupancy, input ready);
  modport sink   (input valid, status, out_payload, out_length, out_priority,
                  out_sequence, occupancy, output ready);
endinterface

// File: rtl/core/msq_ram.sv
// Entry store: one write port, one read port with registered read data.
module msq_ram
  import msq_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/mode_selectable_message_queue.sv
// Clear, full enqueue, empty request and an enqueue in FIFO or LIFO mode or into an empty
// queue: result loaded from idle; dequeue and peek: head read from the store, then S_HEAD.
// Priority enqueue: a read and a compare per entry searched, then a write at the tail if it lands
// there, else a read and a write per entry moved up and the insert (single store read/write port).
// Throughput: one command at a time; the next is taken once the result register is free.
// Reset clears state, count, sequence and head pointer, valid flag and config; not the store.
module mode_selectable_message_queue
  import msq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  msq_in_if.sink      in_ch,
  msq_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  state_t state_r, state_nxt;
  logic [1:0]       mode_r;
  logic [6:0]       cap_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  entry_t           new_r, new_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt, idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;
  entry_t           res_r, res_nxt;
  logic [6:0]       occ_r, occ_nxt;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rdata;
  logic             accept, full, load;
  logic [CNT_W-1:0] limit;
  entry_t           in_entry;

  msq_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_CAP) ? {25'd0, cap_r} :
                      (cfg_paddr == REG_MODE) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FIFO;
      cap_r  <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == REG_MODE) mode_r <= cfg_pwdata[1:0];
      if (cfg_paddr == REG_CAP)  cap_r  <= cfg_pwdata[6:0];
    end
  end

  // Admission and capacity limit.
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign limit       = (cap_r == '0 || cap_r > 7'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_r);
  assign full        = count_r >= limit;
  assign in_entry    = '{payload: in_ch.payload, length: in_ch.msg_length,
                         prio: in_ch.msg_priority, seq_num: seq_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.cmd inside {CMD_DEQ, CMD_PEEK} && count_r != '0) begin
            state_nxt = S_HEAD;
          end else if (in_ch.cmd == CMD_ENQ && !full && mode_r == MODE_PRIO
                       && count_r != '0) begin
            state_nxt = S_SRCH_RD;
          end
        end
      end
      S_HEAD:     state_nxt = S_IDLE;
      S_SRCH_RD:  state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (rdata.prio > new_r.prio) begin
          state_nxt = (pos_r + 1'b1 == count_r) ? S_IDLE : S_SRCH_RD;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = (idx_r - 1'b1 == pos_r) ? S_INSERT : S_SHIFT_RD;
      S_INSERT:   state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath control and result.
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    seq_nxt   = seq_r;
    cmd_nxt   = cmd_r;
    new_nxt   = new_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    we        = 1'b0;
    waddr     = head_r;
    wdata     = new_r;
    re        = 1'b0;
    raddr     = head_r;
    load       = 1'b0;
    status_nxt = ST_OK;
    res_nxt    = '0;
    occ_nxt    = 7'(count_r);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_ch.cmd;
          new_nxt = in_entry;
          pos_nxt = '0;
          case (in_ch.cmd)
            CMD_ENQ: begin
              if (full) begin
                load       = 1'b1;
                status_nxt = ST_FULL;
              end else if (mode_r == MODE_PRIO && count_r != '0) begin
                load = 1'b0;
              end else begin
                we    = 1'b1;
                wdata = in_entry;
                if (mode_r == MODE_LIFO) begin
                  waddr    = head_r - 1'b1;
                  head_nxt = head_r - 1'b1;
                end else begin
                  waddr = head_r + count_r[IDX_W-1:0];
                end
                count_nxt = count_r + 1'b1;
                seq_nxt   = seq_r + 1'b1;
                load      = 1'b1;
                occ_nxt   = 7'(count_r + 1'b1);
              end
            end
            CMD_DEQ, CMD_PEEK: begin
              if (count_r == '0) begin
                load       = 1'b1;
                status_nxt = ST_EMPTY;
              end else begin
                re    = 1'b1;
                raddr = head_r;
              end
            end
            default: begin
              count_nxt = '0;
              load      = 1'b1;
              occ_nxt   = '0;
            end
          endcase
        end
      end
      S_HEAD: begin
        load    = 1'b1;
        res_nxt = rdata;
        if (cmd_r == CMD_DEQ) begin
          head_nxt  = head_r + 1'b1;
          count_nxt = count_r - 1'b1;
          occ_nxt   = 7'(count_r - 1'b1);
        end
      end
      S_SRCH_RD: begin
        re    = 1'b1;
        raddr = head_r + pos_r[IDX_W-1:0];
      end
      S_SRCH_CMP: begin
        if (rdata.prio > new_r.prio) begin
          pos_nxt = pos_r + 1'b1;
          if (pos_r + 1'b1 == count_r) begin
            // Lowest priority so far: goes to the tail, nothing moves.
            we        = 1'b1;
            waddr     = head_r + count_r[IDX_W-1:0];
            count_nxt = count_r + 1'b1;
            seq_nxt   = seq_r + 1'b1;
            load      = 1'b1;
            occ_nxt   = 7'(count_r + 1'b1);
          end
        end else begin
          idx_nxt = count_r;
        end
      end
      S_SHIFT_RD: begin
        re    = 1'b1;
        raddr = head_r + idx_r[IDX_W-1:0] - 1'b1;
      end
      S_SHIFT_WR: begin
        we      = 1'b1;
        waddr   = head_r + idx_r[IDX_W-1:0];
        wdata   = rdata;
        idx_nxt = idx_r - 1'b1;
      end
      S_INSERT: begin
        we        = 1'b1;
        waddr     = head_r + pos_r[IDX_W-1:0];
        count_nxt = count_r + 1'b1;
        seq_nxt   = seq_r + 1'b1;
        load      = 1'b1;
        occ_nxt   = 7'(count_r + 1'b1);
      end
      default: ;
    endcase
    out_valid_nxt = load || (out_valid_r && !out_ch.ready);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command and result registers.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    new_r <= new_nxt;
    pos_r <= pos_nxt;
    idx_r <= idx_nxt;
    if (load) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      occ_r    <= occ_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.out_payload  = res_r.payload;
  assign out_ch.out_length   = res_r.length;
  assign out_ch.out_priority = res_r.prio;
  assign out_ch.out_sequence = res_r.seq_num;
  assign out_ch.occupancy    = occ_r;

  // The entry count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("entry count beyond depth");

  // A clear leaves an empty queue behind.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.cmd == CMD_CLEAR) |=> (count_r == '0 && occ_r == '0))
    else $error("clear did not empty the queue");

  // While an item is being worked on no result is waiting.
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r) else $error("result pending while busy");

  // A full enqueue stores nothing and keeps the counter.
  a_full_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.cmd == CMD_ENQ && full) |=> ($stable(count_r) && $stable(seq_r)))
    else $error("full enqueue changed state");

endmodule
